// File: hdl/chr_pkg.sv
// Shared constants, codes and state type for the consistent hash ring core.
// Used by chr_mix, chr_ram instances and consistent_hash_ring_core.
package chr_pkg;

    localparam int RING_DEPTH = 256;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int LABEL_W    = 19;
    localparam int HASH_W     = 32;
    localparam int SERVER_W   = 17;
    localparam int ENTRY_W    = HASH_W + LABEL_W;

    localparam logic [HASH_W-1:0]  MIX_MUL      = 32'h045d_9f3b;
    localparam logic [LABEL_W-1:0] REPLICA_STEP = 19'd100000;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_ADD    = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LK_RD,
        S_LK_CHK,
        S_MOD,
        S_MIX,
        S_MIX_WAIT,
        S_INS_RD,
        S_INS_CHK,
        S_DEL_RD,
        S_DEL_CHK,
        S_DEL_SH,
        S_DEL_SHW,
        S_REP_NEXT,
        S_FIN
    } state_t;

endpackage

// File: hdl/chr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module chr_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/chr_mix.sv
// Two-stage integer mix hash unit: start passes through v1_reg and v2_reg to done.
// Depends on chr_pkg.
module chr_mix (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [31:0]          x,
    output logic                 done,
    output logic [31:0]          hash
);
    import chr_pkg::*;

    logic [HASH_W-1:0] p1_reg, p2_reg;
    logic              v1_reg, v2_reg;
    logic [HASH_W-1:0] f1, f2;

    assign f1 = (x >> 16) ^ x;
    assign f2 = (p1_reg >> 16) ^ p1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
        end
        p1_reg <= f1 * MIX_MUL;
        p2_reg <= f2 * MIX_MUL;
    end

    assign done = v2_reg;
    assign hash = (p2_reg >> 16) ^ p2_reg;

endmodule

// File: hdl/consistent_hash_ring_core.sv
// Consistent hash ring core: sorted replica ring in one RAM plus sequencer.
// Lookup: scans ring entries in order, then applies the mod-100000 step to the label.
// Add/remove: three replicas, each hashed by chr_mix, then ring entries are scanned or
// shifted in the ring RAM (one read and one write port).
// One request is processed at a time; a finished result waits in an output register.
// Reset (aresetn low, synchronous) empties the ring; RAM contents are not cleared.
module consistent_hash_ring_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // key_hash[31:0], srv_id[48:32], zero pad
    input  logic [1:0]  s_tuser,   // req_type[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // chosen_server[16:0], status[18:17],
                                   // ring_entries[27:19], zero pad
);
    import chr_pkg::*;

    // Each RAM entry holds {hash, label} so the scan never recomputes hashes.
    state_t state_reg, state_next;

    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [1:0]          rep_reg, rep_next;
    req_t                req_reg, req_next;
    logic [HASH_W-1:0]   key_reg, key_next;
    logic [SERVER_W-1:0] sid_reg, sid_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [LABEL_W-1:0]  new_reg, new_next;
    logic [LABEL_W-1:0]  first_reg, first_next;
    logic [LABEL_W-1:0]  lab_reg, lab_next;
    status_t             status_reg, status_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_data_reg, out_data_next;
    logic                mix_go_reg, mix_go_next;

    logic               ram_wr_en, ram_rd_en;
    logic [ADDR_W-1:0]  ram_wr_addr, ram_rd_addr;
    logic [ENTRY_W-1:0] ram_wr_data, ram_rd_data;
    logic [HASH_W-1:0]  rd_hash;
    logic [LABEL_W-1:0] rd_label;

    logic               mix_start, mix_done;
    logic [HASH_W-1:0]  mix_hash;

    logic               s_accept, out_free, last_idx;
    logic [CNT_W-1:0]   idx_m1, idx_p1;
    logic [CNT_W:0]     cnt_plus3;

    chr_ram #(.DATA_W(ENTRY_W), .ADDR_W(ADDR_W)) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    chr_mix u_mix (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mix_start),
        .x       ({{(HASH_W-LABEL_W){1'b0}}, new_reg}),
        .done    (mix_done),
        .hash    (mix_hash)
    );

    assign rd_hash   = ram_rd_data[ENTRY_W-1:LABEL_W];
    assign rd_label  = ram_rd_data[LABEL_W-1:0];
    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign idx_m1    = idx_reg - 1'b1;
    assign idx_p1    = idx_reg + 1'b1;
    assign last_idx  = (idx_p1 == cnt_reg);
    assign cnt_plus3 = {1'b0, cnt_reg} + (CNT_W+1)'(3);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            mix_go_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            mix_go_reg    <= mix_go_next;
        end
        idx_reg      <= idx_next;
        rep_reg      <= rep_next;
        req_reg      <= req_next;
        key_reg      <= key_next;
        sid_reg      <= sid_next;
        hash_reg     <= hash_next;
        new_reg      <= new_next;
        first_reg    <= first_next;
        lab_reg      <= lab_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (req_t'(s_tuser))
                        REQ_LOOKUP: state_next = (cnt_reg == '0) ? S_FIN : S_LK_RD;
                        REQ_ADD:    state_next = (cnt_plus3 > (CNT_W+1)'(RING_DEPTH))
                                                 ? S_FIN : S_MIX;
                        REQ_REMOVE: state_next = (cnt_reg == '0) ? S_FIN : S_MIX;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_LK_RD:  state_next = S_LK_CHK;
            S_LK_CHK: begin
                if (key_reg <= rd_hash || last_idx) begin
                    state_next = S_MOD;
                end else begin
                    state_next = S_LK_RD;
                end
            end
            S_MOD: begin
                if (lab_reg < REPLICA_STEP) begin
                    state_next = S_FIN;
                end
            end
            S_MIX:      state_next = S_MIX_WAIT;
            S_MIX_WAIT: begin
                if (mix_done) begin
                    if (req_reg == REQ_ADD) begin
                        state_next = S_INS_RD;
                    end else if (cnt_reg == '0) begin
                        state_next = S_REP_NEXT;
                    end else begin
                        state_next = S_DEL_RD;
                    end
                end
            end
            S_INS_RD:  state_next = (idx_reg == '0) ? S_REP_NEXT : S_INS_CHK;
            S_INS_CHK: state_next = (hash_reg < rd_hash) ? S_INS_RD : S_REP_NEXT;
            S_DEL_RD:  state_next = S_DEL_CHK;
            S_DEL_CHK: begin
                if (hash_reg <= rd_hash || last_idx) begin
                    state_next = S_DEL_SH;
                end else begin
                    state_next = S_DEL_RD;
                end
            end
            S_DEL_SH:   state_next = last_idx ? S_REP_NEXT : S_DEL_SHW;
            S_DEL_SHW:  state_next = S_DEL_SH;
            S_REP_NEXT: state_next = (rep_reg == 2'd2) ? S_FIN : S_MIX;
            S_FIN: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, RAM control and output register.
    always_comb begin
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        rep_next       = rep_reg;
        req_next       = req_reg;
        key_next       = key_reg;
        sid_next       = sid_reg;
        hash_next      = hash_reg;
        new_next       = new_reg;
        first_next     = first_reg;
        lab_next       = lab_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg[ADDR_W-1:0];
        ram_wr_data    = ram_rd_data;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = idx_reg[ADDR_W-1:0];
        mix_start      = 1'b0;
        mix_go_next    = (state_reg == S_MIX);

        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    req_next    = req_t'(s_tuser);
                    key_next    = s_tdata[31:0];
                    sid_next    = s_tdata[48:32];
                    idx_next    = '0;
                    rep_next    = 2'd0;
                    lab_next    = '0;
                    status_next = ST_OK;
                    if ((req_t'(s_tuser) == REQ_LOOKUP || req_t'(s_tuser) == REQ_REMOVE)
                        && cnt_reg == '0) begin
                        status_next = ST_EMPTY;
                    end else if (req_t'(s_tuser) == REQ_ADD
                                 && cnt_plus3 > (CNT_W+1)'(RING_DEPTH)) begin
                        status_next = ST_FULL;
                    end
                end
            end
            S_LK_RD: begin
                ram_rd_en = 1'b1;
            end
            S_LK_CHK: begin
                if (idx_reg == '0) begin
                    first_next = rd_label;
                end
                if (key_reg <= rd_hash) begin
                    lab_next = rd_label;
                end else if (last_idx) begin
                    // No entry at or above the key: wrap to the first entry.
                    lab_next = (idx_reg == '0) ? rd_label : first_reg;
                end
                idx_next = idx_p1;
            end
            S_MOD: begin
                if (lab_reg >= REPLICA_STEP) begin
                    lab_next = lab_reg - REPLICA_STEP;
                end
            end
            S_MIX: begin
                new_next = LABEL_W'({2'b0, sid_reg} + 19'(rep_reg) * REPLICA_STEP);
            end
            S_MIX_WAIT: begin
                // The label register is settled here, so the unit starts in the cycle after S_MIX.
                mix_start = mix_go_reg;
                if (mix_done) begin
                    hash_next = mix_hash;
                    idx_next  = (req_reg == REQ_ADD) ? cnt_reg : '0;
                end
            end
            S_INS_RD: begin
                if (idx_reg == '0) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_data = {hash_reg, new_reg};
                    cnt_next    = cnt_reg + 1'b1;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_m1[ADDR_W-1:0];
                end
            end
            S_INS_CHK: begin
                ram_wr_en = 1'b1;
                if (hash_reg < rd_hash) begin
                    ram_wr_data = ram_rd_data;
                    idx_next    = idx_m1;
                end else begin
                    ram_wr_data = {hash_reg, new_reg};
                    cnt_next    = cnt_reg + 1'b1;
                end
            end
            S_DEL_RD: begin
                ram_rd_en = 1'b1;
            end
            S_DEL_CHK: begin
                if (!(hash_reg <= rd_hash || last_idx)) begin
                    idx_next = idx_p1;
                end
            end
            S_DEL_SH: begin
                if (last_idx) begin
                    cnt_next = cnt_reg - 1'b1;
                end else begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = idx_p1[ADDR_W-1:0];
                end
            end
            S_DEL_SHW: begin
                ram_wr_en = 1'b1;
                idx_next  = idx_p1;
            end
            S_REP_NEXT: begin
                rep_next = rep_reg + 1'b1;
                idx_next = '0;
            end
            S_FIN: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'b0, cnt_reg, status_reg, lab_reg[SERVER_W-1:0]};
                end
            end
            default: begin
            end
        endcase
    end

endmodule
